FILE: src/dcssd_pkg.sv
`default_nettype none

package dcssd_pkg;

   localparam int DEFAULT_DIGITS = 6;
   localparam int LOAD_WIDTH     = 20;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_INCR   = 2'd1,
      CMD_ZERO   = 2'd2,
      CMD_REDRAW = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                 command;
      logic [LOAD_WIDTH-1:0]   load_value;
   } req_type;

   typedef struct packed {
      logic [2:0] digit_place;
      logic [6:0] segments;
      logic       last;
   } rsp_type;

   // a=bit0 .. g=bit6
   function automatic logic [6:0] seg_of(input logic [3:0] digit);
      logic [6:0] pattern;
      case (digit)
         4'd0: pattern = 7'h3F;
         4'd1: pattern = 7'h06;
         4'd2: pattern = 7'h5B;
         4'd3: pattern = 7'h4F;
         4'd4: pattern = 7'h66;
         4'd5: pattern = 7'h6D;
         4'd6: pattern = 7'h7D;
         4'd7: pattern = 7'h27;
         4'd8: pattern = 7'h7F;
         4'd9: pattern = 7'h6F;
         default: pattern = 7'h00;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

FILE: src/decimal_counter_seven_segment_driver_top.sv
`default_nettype none
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  command, load_value
// rsp_      out        rsp_valid/rsp_stall  digit_place, segments, last
//
// A command passes through accept, then (load only) one binary-to-decimal shift step per
//   load bit, one digit walk step per place, a blank phase over the places to blank, a
//   draw phase over the places in use, and finish.
// Reset clears the count to zero with one place in use and emits nothing.
// req_stall stays high from accept until the command finishes, loading its last word if any.
// A held rsp_ word stalls finish while a word is parked; the scan only if another is found.
module decimal_counter_seven_segment_driver_top #(
   parameter int DIGITS = dcssd_pkg::DEFAULT_DIGITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dcssd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dcssd_pkg::rsp_type     rsp_data
);
   import dcssd_pkg::*;

   localparam int PW = $clog2(DIGITS + 1);           // holds 0..DIGITS
   localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int CW = $clog2(LOAD_WIDTH);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CONV   = 6'b000010,
      ST_WALK   = 6'b000100,
      ST_BLANK  = 6'b001000,
      ST_DRAW   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               op_ff, op_in;
   logic [LOAD_WIDTH-1:0] bin_ff, bin_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [PW-1:0]         p_ff, p_in;
   logic [PW-1:0]         len_ff, len_in;
   logic [PW-1:0]         newlen_ff, newlen_in;
   logic                  carry_ff, carry_in;
   logic [3:0]            shown_ff [DIGITS];
   logic [3:0]            shown_in [DIGITS];
   logic [3:0]            next_ff  [DIGITS];
   logic [3:0]            next_in  [DIGITS];
   logic [3:0]            adj      [DIGITS];
   logic                  pend_vld_ff, pend_vld_in;
   rsp_type               pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [IW-1:0]         idx;
   logic [3:0]            cur_next, cur_shown, walk_digit;
   logic [PW-1:0]         walk_len, blank_hi;
   logic                  out_busy, hit, hold;
   rsp_type               cand;

   assign idx       = p_ff[IW-1:0];
   assign cur_next  = next_ff[idx];
   assign cur_shown = shown_ff[idx];
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign blank_hi  = (op_ff == CMD_REDRAW) ? PW'(DIGITS) : len_ff;

   // Add-3 adjust per place; independent, so all places step together.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[i] = (next_ff[i] >= 4'd5) ? (next_ff[i] + 4'd3) : next_ff[i];
      end
   end

   // Next digit of the walk: copy, increment with ripple carry, or clear.
   always_comb begin
      carry_in   = carry_ff;
      walk_digit = cur_shown;
      case (op_ff)
         CMD_LOAD: walk_digit = cur_next;
         CMD_INCR: begin
            if (carry_ff) begin
               carry_in   = (cur_shown == 4'd9);
               walk_digit = (cur_shown == 4'd9) ? 4'd0 : (cur_shown + 4'd1);
            end
         end
         CMD_ZERO: walk_digit = 4'd0;
         default:  walk_digit = cur_shown;
      endcase
      walk_len = (walk_digit != 4'd0) ? (p_ff + PW'(1)) : newlen_ff;
   end

   // Candidate word at the current place.
   always_comb begin
      hit              = 1'b0;
      cand.digit_place = 3'(p_ff);
      cand.segments    = 7'h00;
      cand.last        = 1'b0;
      if (state_ff == ST_BLANK) begin
         hit = (p_ff < blank_hi);
      end else if (state_ff == ST_DRAW) begin
         hit = (p_ff < newlen_ff) &&
               ((op_ff == CMD_REDRAW) || (p_ff >= len_ff) || (cur_next != cur_shown));
         cand.segments = seg_of(cur_next);
      end
   end

   // Pause the scan when a second word is found while the output waits.
   assign hold = hit && pend_vld_ff && out_busy;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      p_in         = p_ff;
      len_in       = len_ff;
      newlen_in    = newlen_ff;
      shown_in     = shown_ff;
      next_in      = next_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.command;
               bin_in    = req_data.load_value;
               cnt_in    = '0;
               p_in      = '0;
               newlen_in = PW'(1);
               for (int i = 0; i < DIGITS; i++) begin
                  next_in[i] = 4'd0;
               end
               state_in = (req_data.command == CMD_LOAD) ? ST_CONV : ST_WALK;
            end
         end
         ST_CONV: begin
            // Shift one binary bit into the decimal digits per cycle; the carry
            // out of the top place drops, which keeps the value modulo 10^DIGITS.
            next_in[0] = {adj[0][2:0], bin_ff[LOAD_WIDTH-1]};
            for (int i = 1; i < DIGITS; i++) begin
               next_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(LOAD_WIDTH - 1)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            next_in[idx] = walk_digit;
            newlen_in    = walk_len;
            p_in         = p_ff + PW'(1);
            if (p_ff == PW'(DIGITS - 1)) begin
               state_in = ST_BLANK;
               if (op_ff == CMD_REDRAW) begin
                  newlen_in = len_ff;
                  p_in      = len_ff;
               end else begin
                  p_in = walk_len;
               end
            end
         end
         ST_BLANK, ST_DRAW: begin
            if (!hold) begin
               if (hit) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_ff;
                  end
                  pend_vld_in = 1'b1;
                  pend_in     = cand;
               end
               if (state_ff == ST_BLANK) begin
                  if (hit) begin
                     p_in = p_ff + PW'(1);
                  end else begin
                     p_in     = '0;
                     state_in = ST_DRAW;
                  end
               end else begin
                  if (p_ff < newlen_ff) begin
                     p_in = p_ff + PW'(1);
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!pend_vld_ff || !out_busy) begin
               if (pend_vld_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_data_in      = pend_ff;
                  rsp_data_in.last = 1'b1;
               end
               pend_vld_in = 1'b0;
               shown_in    = next_ff;
               len_in      = newlen_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= PW'(1);
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIGITS; i++) begin
            shown_ff[i] <= 4'd0;
         end
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         shown_ff     <= shown_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      p_ff        <= p_in;
      newlen_ff   <= newlen_in;
      carry_ff    <= (state_ff == ST_IDLE) ? 1'b1 : carry_in;
      next_ff     <= next_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No word may be parked behind the output once the command has finished.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("pending word left over in idle");

   // Places in use stay within the display.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) && (len_ff <= PW'(DIGITS)))
      else $error("length out of range");

   // A word found in the blank phase carries a dark pattern.
   a_blank_dark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLANK && hit && !hold) |=> (pend_ff.segments == 7'h00))
      else $error("blank place drawn");

   // Leaving finish flags the word it pushes as the last one.
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && pend_vld_ff && !out_busy) |=> (rsp_valid && rsp_data.last))
      else $error("final word not flagged");

endmodule

`default_nettype wire

FILE: test/segment_update_checker.sv
`default_nettype none

module segment_update_checker #(
   parameter int DIGITS = 6
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire dcssd_pkg::req_type req_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire dcssd_pkg::rsp_type rsp_data,
   output int                      mismatches,
   output int                      awaited
);
   import dcssd_pkg::*;

   logic [6:0] glyph [0:9];
   logic [3:0] count_digits [DIGITS];
   int         lit_places;
   int         fail_total = 0;
   rsp_type    repaint_q [$];

   initial begin
      glyph[0] = 7'h3F; glyph[1] = 7'h06; glyph[2] = 7'h5B; glyph[3] = 7'h4F;
      glyph[4] = 7'h66; glyph[5] = 7'h6D; glyph[6] = 7'h7D; glyph[7] = 7'h27;
      glyph[8] = 7'h7F; glyph[9] = 7'h6F;
   end

   // Apply one command to the shadow count and queue the display words it causes.
   task automatic plan_repaint(input req_type w);
      logic [3:0]  next_digits [DIGITS];
      logic [2:0]  places [16];
      logic [6:0]  pats [16];
      rsp_type     word;
      int unsigned rest;
      int          new_len;
      int          n;
      int          p;
      bit          carry;
      n = 0;
      if (w.command == CMD_REDRAW) begin
         for (p = lit_places; p < DIGITS; p++) begin
            places[n] = p[2:0]; pats[n] = 7'h00; n++;
         end
         for (p = 0; p < lit_places; p++) begin
            places[n] = p[2:0]; pats[n] = glyph[count_digits[p]]; n++;
         end
      end else begin
         rest  = 32'(w.load_value);
         carry = 1'b1;
         for (p = 0; p < DIGITS; p++) begin
            case (w.command)
               CMD_LOAD: begin
                  next_digits[p] = 4'(rest % 10);
                  rest = rest / 10;
               end
               CMD_INCR: begin
                  if (!carry) begin
                     next_digits[p] = count_digits[p];
                  end else if (count_digits[p] == 4'd9) begin
                     next_digits[p] = 4'd0;
                  end else begin
                     next_digits[p] = count_digits[p] + 4'd1;
                     carry = 1'b0;
                  end
               end
               default: next_digits[p] = 4'd0;
            endcase
         end
         new_len = 1;
         for (p = 0; p < DIGITS; p++)
            if (next_digits[p] != 4'd0) new_len = p + 1;
         // blank places dropped by a shorter number
         for (p = new_len; p < lit_places; p++) begin
            places[n] = p[2:0]; pats[n] = 7'h00; n++;
         end
         // draw changed digits and anything that was blank before
         for (p = 0; p < new_len; p++) begin
            if (p >= lit_places || next_digits[p] != count_digits[p]) begin
               places[n] = p[2:0]; pats[n] = glyph[next_digits[p]]; n++;
            end
         end
         for (p = 0; p < DIGITS; p++) count_digits[p] = next_digits[p];
         lit_places = new_len;
      end
      for (p = 0; p < n; p++) begin
         word.digit_place = places[p];
         word.segments    = pats[p];
         word.last        = (p == n - 1);
         repaint_q.push_back(word);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      int      p;
      if (reset) begin
         for (p = 0; p < DIGITS; p++) count_digits[p] = 4'd0;
         lit_places = 1;
         repaint_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (repaint_q.size() == 0) begin
               fail_total++;
               $display("%0t: unexpected word, got place %0d seg %h last %b", $time,
                        rsp_data.digit_place, rsp_data.segments, rsp_data.last);
            end else begin
               want = repaint_q.pop_front();
               if (rsp_data.digit_place !== want.digit_place) begin
                  fail_total++;
                  $display("%0t: digit_place expected %0d got %0d", $time,
                           want.digit_place, rsp_data.digit_place);
               end
               if (rsp_data.segments !== want.segments) begin
                  fail_total++;
                  $display("%0t: segments expected %h got %h", $time,
                           want.segments, rsp_data.segments);
               end
               if (rsp_data.last !== want.last) begin
                  fail_total++;
                  $display("%0t: last expected %b got %b", $time, want.last, rsp_data.last);
               end
            end
         end
         if (req_valid && !req_stall) plan_repaint(req_data);
      end
      mismatches <= fail_total;
      awaited    <= repaint_q.size();
   end

endmodule

`default_nettype wire

FILE: test/decimal_counter_seven_segment_driver_top_tb.sv
`default_nettype none

module decimal_counter_seven_segment_driver_top_tb;
   import dcssd_pkg::*;

   localparam int DIGITS         = 6;
   localparam int RANDOM_ITEMS   = 330;
   // No command should leave both channels silent for this long, even with
   // a 20-step conversion, six stalled words and the longest sender gap.
   localparam int WATCHDOG_LIMIT = 3000;
   // Give margin after the drain for the slowest command to finish.
   localparam int SETTLE_CYCLES  = 60;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatches;
   int awaited;

   int          burst_left   = 0;
   int          sent         = 0;
   int          quiet_cycles = 0;
   int unsigned stall_mode   = 0;
   int unsigned stall_left   = 0;

   always #4 clock = ~clock;

   decimal_counter_seven_segment_driver_top #(.DIGITS(DIGITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   segment_update_checker #(.DIGITS(DIGITS)) update_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   // Receiver back-pressure: switch among four stall styles at random intervals so
   // that stalls land on every phase of the place scan.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;                        // drain freely
         1:       rsp_stall <= ($urandom_range(0, 1) == 0);  // coin flip
         2:       rsp_stall <= ($urandom_range(0, 7) != 0);  // mostly held
         default: rsp_stall <= (stall_left[1:0] != 2'd0);    // periodic
      endcase
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("decimal_counter_seven_segment_driver_top_tb NOT OK");
         $finish;
      end
   end

   // Offer one command word and hold it until accepted. After each burst,
   // drop valid for a random gap, or keep going with no gap at all.
   task automatic issue(input cmd_type c, input logic [LOAD_WIDTH-1:0] v);
      int gap;
      req_data  <= '{command: c, load_value: v};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Hold off the sender until every predicted word has come back.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   // Load values: mostly in range, some small, some round, some just under a power
   // of ten to set up carry chains, and some past 999999 to test truncation.
   function automatic logic [LOAD_WIDTH-1:0] draw_load_value;
      int unsigned p10;
      int unsigned k;
      case ($urandom_range(0, 5))
         0: return LOAD_WIDTH'($urandom_range(0, 1048575));
         1: return LOAD_WIDTH'($urandom_range(0, 999999));
         2: return LOAD_WIDTH'($urandom_range(0, 30));
         3: begin
            k = $urandom_range(1, 6);
            p10 = 1;
            repeat (k) p10 = p10 * 10;
            return LOAD_WIDTH'(p10 - 1 - $urandom_range(0, 3));
         end
         4: begin
            k = $urandom_range(0, 5);
            p10 = 1;
            repeat (k) p10 = p10 * 10;
            return LOAD_WIDTH'(p10 * $urandom_range(1, 9));
         end
         default: return LOAD_WIDTH'($urandom_range(1000000, 1048575));
      endcase
   endfunction

   initial begin : stimulus
      int  pick;
      bit  mid_drained;
      mid_drained = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      issue(CMD_REDRAW, 20'd0);        // after reset: blank upper places, draw a zero
      issue(CMD_LOAD,   20'd0);        // no change, no words
      issue(CMD_ZERO,   20'd0);        // no change, no words
      issue(CMD_INCR,   20'd0);
      issue(CMD_LOAD,   20'd101);      // zero drawn at a place that was blank
      issue(CMD_LOAD,   20'd999999);   // every place drawn
      issue(CMD_REDRAW, 20'd0);        // full length, nothing blanked
      issue(CMD_INCR,   20'd0);        // wrap from all nines to zero
      issue(CMD_LOAD,   20'hFFFFF);    // over range, keep low six digits
      issue(CMD_LOAD,   20'd1000000);  // over range, folds to zero
      issue(CMD_LOAD,   20'd99);
      issue(CMD_INCR,   20'd0);        // carry into a new place
      issue(CMD_LOAD,   20'd100);      // same value, no words
      issue(CMD_LOAD,   20'd123456);
      issue(CMD_ZERO,   20'd0);        // blank five places at once
      issue(CMD_LOAD,   20'd9);
      issue(CMD_INCR,   20'hFFFFF);    // load field ignored on increment
      issue(CMD_REDRAW, 20'hFFFFF);
      issue(CMD_ZERO,   20'hAAAAA);
      issue(CMD_LOAD,   20'd500000);
      issue(CMD_LOAD,   20'd7);
      drain();

      // Random part: load-then-count runs dominate, mixed with lone commands.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            issue(CMD_LOAD, draw_load_value());
            repeat ($urandom_range(0, 10))
               issue(CMD_INCR, LOAD_WIDTH'($urandom_range(0, 1048575)));
         end else if (pick < 6) begin
            issue(CMD_INCR, LOAD_WIDTH'($urandom_range(0, 1048575)));
         end else if (pick == 6) begin
            issue(CMD_ZERO, LOAD_WIDTH'($urandom_range(0, 1048575)));
            repeat ($urandom_range(0, 4))
               issue(CMD_INCR, LOAD_WIDTH'($urandom_range(0, 1048575)));
         end else if (pick == 7) begin
            issue(CMD_REDRAW, LOAD_WIDTH'($urandom_range(0, 1048575)));
         end else begin
            issue(CMD_LOAD, draw_load_value());
         end
         if (!mid_drained && sent >= RANDOM_ITEMS / 2) begin
            drain();
            mid_drained = 1'b1;
         end
      end

      // Wind down: wait for the last word, then let the block settle.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited == 0)
         $display("decimal_counter_seven_segment_driver_top_tb OK");
      else
         $display("decimal_counter_seven_segment_driver_top_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
